@@ rtl/s3e_pkg.sv @@
// Shared types, constants and the arctangent table of the SO(3) exponential map.
`default_nettype none
package s3e_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STAGES  = 32;  // one root bit per stage of a 64-bit radicand
  localparam int DIV_STAGES   = 31;  // quotient bits 30 down to 0
  localparam int CW           = 36;  // CORDIC x/y and sine/cosine width
  localparam int RW           = 35;  // angle width, Q30

  localparam logic [63:0] SMALL_T = 64'd72058;

  localparam logic signed [RW-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [RW-1:0] FOUR_PI_Q30 = 35'sd13493037704;
  localparam logic signed [RW-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [RW-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [CW-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [CW-1:0] ONE_Q30     = 36'sd1073741824;

  // Lane 0 is x, lane 1 is y, lane 2 is z.
  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    vec_t v;
    logic near_zero;
  } tag_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
  } mat_t;

  function automatic logic signed [RW-1:0] atan_q30(input int i);
    logic signed [RW-1:0] a;
    case (i)
      0: a = 35'sd843314857;
      1: a = 35'sd497837829;
      2: a = 35'sd263043837;
      3: a = 35'sd133525159;
      4: a = 35'sd67021687;
      5: a = 35'sd33543516;
      6: a = 35'sd16775851;
      7: a = 35'sd8388437;
      8: a = 35'sd4194283;
      9: a = 35'sd2097149;
      default: a = (i >= 0 && i <= 30) ? (RW'(1) << (30 - i)) : '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

@@ rtl/s3e_in_if.sv @@
// Input channel carrying one rotation vector per transfer.
`default_nettype none
interface s3e_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rot_x;
  logic signed [31:0] rot_y;
  logic signed [31:0] rot_z;

  modport source (output valid, output rot_x, output rot_y, output rot_z, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z, output ready);
endinterface
`default_nettype wire

@@ rtl/s3e_out_if.sv @@
// Result channel carrying one rotation matrix per transfer.
`default_nettype none
interface s3e_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] m00;
  logic signed [31:0] m01;
  logic signed [31:0] m02;
  logic signed [31:0] m10;
  logic signed [31:0] m11;
  logic signed [31:0] m12;
  logic signed [31:0] m20;
  logic signed [31:0] m21;
  logic signed [31:0] m22;

  modport source (output valid, output m00, output m01, output m02, output m10, output m11,
                  output m12, output m20, output m21, output m22, input ready);
  modport sink   (input valid, input m00, input m01, input m02, input m10, input m11,
                  input m12, input m20, input m21, input m22, output ready);
endinterface
`default_nettype wire

@@ rtl/s3e_square.sv @@
// Two-stage squared norm of the rotation vector and small-angle detection.
`default_nettype none
module s3e_square (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  s3e_pkg::vec_t  in_v,
  output logic           out_valid,
  output s3e_pkg::tag_t  out_tag,
  output logic [63:0]    out_t
);

  logic [2:0][31:0] mag;
  logic [2:0][63:0] sq_r;
  s3e_pkg::vec_t    v1_r;
  logic             val1_r;
  logic             val2_r;
  logic [63:0]      sum;
  logic [63:0]      t_r;
  s3e_pkg::tag_t    tag_r;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag[l] = in_v[l][31] ? (~in_v[l] + 32'd1) : in_v[l];
    end
  end

  assign sum = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
    end else if (en) begin
      val1_r <= in_valid;
      val2_r <= val1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        sq_r[l] <= 64'(mag[l]) * 64'(mag[l]);
      end
      v1_r            <= in_v;
      t_r             <= sum;
      tag_r.v         <= v1_r;
      tag_r.near_zero <= (sum < s3e_pkg::SMALL_T);
    end
  end

  assign out_valid = val2_r;
  assign out_tag   = tag_r;
  assign out_t     = t_r;

endmodule
`default_nettype wire

@@ rtl/s3e_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module s3e_sqrt (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [63:0]    in_t,
  input  s3e_pkg::tag_t  in_tag,
  output logic           out_valid,
  output logic [31:0]    out_theta,
  output s3e_pkg::tag_t  out_tag
);

  localparam int N = s3e_pkg::SQRT_STAGES;

  logic          val_r [N];
  logic [63:0]   n_r   [N];
  logic [63:0]   res_r [N];
  s3e_pkg::tag_t tag_r [N];

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;
    localparam logic [63:0] BIT = 64'(1) << (2 * K);

    logic          val_in;
    logic [63:0]   n_in;
    logic [63:0]   res_in;
    logic [63:0]   trial;
    s3e_pkg::tag_t tag_in;

    if (j == 0) begin : g_first
      assign val_in = in_valid;
      assign n_in   = in_t;
      assign res_in = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign val_in = val_r[j-1];
      assign n_in   = n_r[j-1];
      assign res_in = res_r[j-1];
      assign tag_in = tag_r[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[j] <= 1'b0;
      end else if (en) begin
        val_r[j] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[j] <= tag_in;
        if (n_in >= trial) begin
          n_r[j]   <= n_in - trial;
          res_r[j] <= (res_in >> 1) + BIT;
        end else begin
          n_r[j]   <= n_in;
          res_r[j] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = val_r[N-1];
  assign out_theta = res_r[N-1][31:0];
  assign out_tag   = tag_r[N-1];

endmodule
`default_nettype wire

@@ rtl/s3e_div.sv @@
// Pipelined restoring divider forming the unit axis u = v * 2^30 / theta on three lanes.
`default_nettype none
module s3e_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [31:0]    in_theta,
  input  s3e_pkg::tag_t  in_tag,
  output logic           out_valid,
  output s3e_pkg::vec_t  out_u,
  output logic [31:0]    out_theta,
  output s3e_pkg::tag_t  out_tag
);

  localparam int N = s3e_pkg::DIV_STAGES;

  logic          val_r   [N];
  logic [62:0]   p_r     [N][3];
  logic [30:0]   q_r     [N][3];
  logic [31:0]   theta_r [N];
  s3e_pkg::tag_t tag_r   [N];

  logic          valf_r;
  s3e_pkg::vec_t u_r;
  logic [31:0]   thetaf_r;
  s3e_pkg::tag_t tagf_r;

  for (genvar j = 0; j < N; j++) begin : g_stage
    localparam int K = N - 1 - j;

    logic          val_in;
    logic [62:0]   p_in [3];
    logic [30:0]   q_in [3];
    logic [31:0]   theta_in;
    s3e_pkg::tag_t tag_in;
    logic [62:0]   d;

    if (j == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_in[l] = {1'b0, (in_tag.v[l][31] ? (~in_tag.v[l] + 32'd1) : in_tag.v[l]), 30'd0};
          q_in[l] = '0;
        end
      end
      assign val_in   = in_valid;
      assign theta_in = in_theta;
      assign tag_in   = in_tag;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          p_in[l] = p_r[j-1][l];
          q_in[l] = q_r[j-1][l];
        end
      end
      assign val_in   = val_r[j-1];
      assign theta_in = theta_r[j-1];
      assign tag_in   = tag_r[j-1];
    end

    assign d = 63'(theta_in) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[j] <= 1'b0;
      end else if (en) begin
        val_r[j] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        theta_r[j] <= theta_in;
        tag_r[j]   <= tag_in;
        for (int l = 0; l < 3; l++) begin
          if (p_in[l] >= d) begin
            p_r[j][l] <= p_in[l] - d;
            q_r[j][l] <= q_in[l] | (31'(1) << K);
          end else begin
            p_r[j][l] <= p_in[l];
            q_r[j][l] <= q_in[l];
          end
        end
      end
    end
  end

  // The quotient truncates toward zero, so the sign goes on the magnitude.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valf_r <= 1'b0;
    end else if (en) begin
      valf_r <= val_r[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      thetaf_r <= theta_r[N-1];
      tagf_r   <= tag_r[N-1];
      for (int l = 0; l < 3; l++) begin
        u_r[l] <= tag_r[N-1].v[l][31] ? (32'd0 - {1'b0, q_r[N-1][l]}) : {1'b0, q_r[N-1][l]};
      end
    end
  end

  assign out_valid = valf_r;
  assign out_u     = u_r;
  assign out_theta = thetaf_r;
  assign out_tag   = tagf_r;

endmodule
`default_nettype wire

@@ rtl/s3e_sincos.sv @@
// Range reduction of 4*theta and a pipelined rotation-mode CORDIC for sine and 1 - cosine.
`default_nettype none
module s3e_sincos (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [31:0]                    in_theta,
  input  s3e_pkg::vec_t                  in_u,
  input  s3e_pkg::tag_t                  in_tag,
  output logic                           out_valid,
  output logic signed [s3e_pkg::CW-1:0]  out_s,
  output logic signed [s3e_pkg::CW-1:0]  out_omc,
  output s3e_pkg::vec_t                  out_u,
  output s3e_pkg::tag_t                  out_tag
);

  localparam int N  = s3e_pkg::CORDIC_STEPS;
  localparam int CW = s3e_pkg::CW;
  localparam int RW = s3e_pkg::RW;

  typedef struct packed {
    s3e_pkg::vec_t u;
    s3e_pkg::tag_t tag;
  } side_t;

  side_t                in_side;
  logic signed [RW-1:0] r0;

  logic                 val1_r, val2_r, val3_r, val4_r;
  side_t                side1_r, side2_r, side3_r, side4_r;
  logic signed [RW-1:0] r1_r, r2_r, r3_r, z4_r;
  logic                 flip4_r;

  logic                 val_r  [N];
  logic signed [CW-1:0] x_r    [N];
  logic signed [CW-1:0] y_r    [N];
  logic signed [RW-1:0] z_r    [N];
  logic                 flip_r [N];
  side_t                side_r [N];

  logic                 valf_r;
  logic signed [CW-1:0] s_r;
  logic signed [CW-1:0] omc_r;
  side_t                sidef_r;

  assign in_side.u   = in_u;
  assign in_side.tag = in_tag;
  assign r0          = $signed({1'b0, in_theta, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
      val3_r <= 1'b0;
      val4_r <= 1'b0;
    end else if (en) begin
      val1_r <= in_valid;
      val2_r <= val1_r;
      val3_r <= val2_r;
      val4_r <= val3_r;
    end
  end

  // 4*theta is below three turns, so two conditional subtractions finish the modulo.
  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= in_side;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
      r1_r    <= (r0 >= s3e_pkg::FOUR_PI_Q30) ? r0 - s3e_pkg::FOUR_PI_Q30 : r0;
      r2_r    <= (r1_r >= s3e_pkg::TWO_PI_Q30) ? r1_r - s3e_pkg::TWO_PI_Q30 : r1_r;
      r3_r    <= (r2_r > s3e_pkg::PI_Q30) ? r2_r - s3e_pkg::TWO_PI_Q30 : r2_r;
      if (r3_r > s3e_pkg::HALF_PI_Q30) begin
        z4_r    <= s3e_pkg::PI_Q30 - r3_r;
        flip4_r <= 1'b1;
      end else if (r3_r < -s3e_pkg::HALF_PI_Q30) begin
        z4_r    <= -s3e_pkg::PI_Q30 - r3_r;
        flip4_r <= 1'b1;
      end else begin
        z4_r    <= r3_r;
        flip4_r <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [RW-1:0] AT = s3e_pkg::atan_q30(i);

    logic                 val_in;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [RW-1:0] z_in;
    logic                 flip_in;
    side_t                side_in;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (i == 0) begin : g_first
      assign val_in  = val4_r;
      assign x_in    = s3e_pkg::GAIN_Q30;
      assign y_in    = '0;
      assign z_in    = z4_r;
      assign flip_in = flip4_r;
      assign side_in = side4_r;
    end else begin : g_next
      assign val_in  = val_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign flip_in = flip_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[i] <= 1'b0;
      end else if (en) begin
        val_r[i] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i] <= flip_in;
        side_r[i] <= side_in;
        if (!z_in[RW-1]) begin
          x_r[i] <= x_in - dx;
          y_r[i] <= y_in + dy;
          z_r[i] <= z_in - AT;
        end else begin
          x_r[i] <= x_in + dx;
          y_r[i] <= y_in - dy;
          z_r[i] <= z_in + AT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valf_r <= 1'b0;
    end else if (en) begin
      valf_r <= val_r[N-1];
    end
  end

  // A mirrored angle keeps its sine and negates its cosine.
  always_ff @(posedge clk) begin
    if (en) begin
      sidef_r <= side_r[N-1];
      s_r     <= y_r[N-1];
      omc_r   <= flip_r[N-1] ? s3e_pkg::ONE_Q30 + x_r[N-1] : s3e_pkg::ONE_Q30 - x_r[N-1];
    end
  end

  assign out_valid = valf_r;
  assign out_s     = s_r;
  assign out_omc   = omc_r;
  assign out_u     = sidef_r.u;
  assign out_tag   = sidef_r.tag;

endmodule
`default_nettype wire

@@ rtl/s3e_compose.sv @@
// Three-stage assembly of R = I + sin*[u]x + (1 - cos)*(u u^T - I) with saturation.
`default_nettype none
module s3e_compose (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic signed [s3e_pkg::CW-1:0]  in_s,
  input  logic signed [s3e_pkg::CW-1:0]  in_omc,
  input  s3e_pkg::vec_t                  in_u,
  input  s3e_pkg::tag_t                  in_tag,
  output logic                           out_valid,
  output s3e_pkg::mat_t                  out_m
);

  localparam int CW = s3e_pkg::CW;

  // Product slots: squares and cross terms of the axis.
  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;

  function automatic logic signed [33:0] rnd_uu(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return 34'((p + 64'sd536870912) >>> 30);
  endfunction

  function automatic logic signed [37:0] rnd_su(input logic signed [CW-1:0] a,
                                                input logic signed [31:0] b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b);
    return 38'((p + 68'sd536870912) >>> 30);
  endfunction

  function automatic logic signed [40:0] rnd_bk(input logic signed [CW-1:0] a,
                                                input logic signed [34:0] b);
    logic signed [70:0] p;
    p = 71'(a) * 71'(b);
    return 41'((p + 71'sd536870912) >>> 30);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
    logic signed [31:0] r;
    if (v > 42'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -42'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  logic                 val1_r, val2_r, val3_r;
  logic signed [33:0]   pp_r  [6];
  logic signed [37:0]   su1_r [3];
  logic signed [37:0]   su2_r [3];
  logic signed [CW-1:0] omc1_r;
  s3e_pkg::tag_t        tag1_r, tag2_r;
  logic signed [40:0]   bk_r  [6];
  s3e_pkg::mat_t        m_r;

  logic signed [34:0]   dg [3];
  logic signed [41:0]   e  [9];
  logic signed [41:0]   one;
  logic signed [41:0]   vx4, vy4, vz4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val1_r <= 1'b0;
      val2_r <= 1'b0;
      val3_r <= 1'b0;
    end else if (en) begin
      val1_r <= in_valid;
      val2_r <= val1_r;
      val3_r <= val2_r;
    end
  end

  // Diagonal weights of u u^T - I, written as minus the other two squares.
  always_comb begin
    dg[0] = -(35'(pp_r[PYY]) + 35'(pp_r[PZZ]));
    dg[1] = -(35'(pp_r[PXX]) + 35'(pp_r[PZZ]));
    dg[2] = -(35'(pp_r[PXX]) + 35'(pp_r[PYY]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[PXX] <= rnd_uu($signed(in_u[0]), $signed(in_u[0]));
      pp_r[PYY] <= rnd_uu($signed(in_u[1]), $signed(in_u[1]));
      pp_r[PZZ] <= rnd_uu($signed(in_u[2]), $signed(in_u[2]));
      pp_r[PXY] <= rnd_uu($signed(in_u[0]), $signed(in_u[1]));
      pp_r[PXZ] <= rnd_uu($signed(in_u[0]), $signed(in_u[2]));
      pp_r[PYZ] <= rnd_uu($signed(in_u[1]), $signed(in_u[2]));
      for (int l = 0; l < 3; l++) begin
        su1_r[l] <= rnd_su(in_s, $signed(in_u[l]));
        su2_r[l] <= su1_r[l];
      end
      omc1_r <= in_omc;
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
      for (int l = 0; l < 3; l++) begin
        bk_r[l] <= rnd_bk(omc1_r, dg[l]);
      end
      bk_r[PXY] <= rnd_bk(omc1_r, 35'(pp_r[PXY]));
      bk_r[PXZ] <= rnd_bk(omc1_r, 35'(pp_r[PXZ]));
      bk_r[PYZ] <= rnd_bk(omc1_r, 35'(pp_r[PYZ]));
    end
  end

  // Below the small-angle threshold the series terms reduce to I + 4K exactly.
  always_comb begin
    one = 42'sd1073741824;
    vx4 = 42'($signed(tag2_r.v[0])) <<< 2;
    vy4 = 42'($signed(tag2_r.v[1])) <<< 2;
    vz4 = 42'($signed(tag2_r.v[2])) <<< 2;
    if (tag2_r.near_zero) begin
      e[0] = one;
      e[1] = -vz4;
      e[2] = vy4;
      e[3] = vz4;
      e[4] = one;
      e[5] = -vx4;
      e[6] = -vy4;
      e[7] = vx4;
      e[8] = one;
    end else begin
      e[0] = one + 42'(bk_r[0]);
      e[1] = -42'(su2_r[2]) + 42'(bk_r[PXY]);
      e[2] = 42'(su2_r[1]) + 42'(bk_r[PXZ]);
      e[3] = 42'(su2_r[2]) + 42'(bk_r[PXY]);
      e[4] = one + 42'(bk_r[1]);
      e[5] = -42'(su2_r[0]) + 42'(bk_r[PYZ]);
      e[6] = -42'(su2_r[1]) + 42'(bk_r[PXZ]);
      e[7] = 42'(su2_r[0]) + 42'(bk_r[PYZ]);
      e[8] = one + 42'(bk_r[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r.m00 <= sat32(e[0]);
      m_r.m01 <= sat32(e[1]);
      m_r.m02 <= sat32(e[2]);
      m_r.m10 <= sat32(e[3]);
      m_r.m11 <= sat32(e[4]);
      m_r.m12 <= sat32(e[5]);
      m_r.m20 <= sat32(e[6]);
      m_r.m21 <= sat32(e[7]);
      m_r.m22 <= sat32(e[8]);
    end
  end

  assign out_valid = val3_r;
  assign out_m     = m_r;

endmodule
`default_nettype wire

@@ rtl/so3_exponential_map.sv @@
// SO(3) exponential map: rotation vector in, rotation matrix out by Rodrigues' formula.
//
// in_chan carries one rotation vector (rot_x, rot_y, rot_z, signed Q4.28 radians) per
// transfer; out_chan carries the nine entries m00..m22 of the matrix in signed Q2.30.
// Both use valid/ready, and a transfer happens on a rising edge with both high.
// One vector is accepted every cycle while the output queue has room. A result passes in
// order through the squared norm, the square root (one root bit per stage), the axis
// divider (one quotient bit per stage plus sign), range reduction and the CORDIC
// (CORDIC_STEPS = 30 stages), the matrix products, and the write into the output queue.
// Results leave through a two-entry output queue. The whole pipeline advances while the
// queue has room, so input is still taken while one finished result waits; when the
// receiver holds ready low and both entries are full, in_chan.ready drops and every
// stage holds its contents until a transfer on out_chan frees an entry.
// A synchronous, active-low rst_n empties the pipeline and the queue; no item is in
// flight after reset and the block takes input in the next cycle.
`default_nettype none
module so3_exponential_map (
  input  logic       clk,
  input  logic       rst_n,
  s3e_in_if.sink     in_chan,
  s3e_out_if.source  out_chan
);

  localparam int CW = s3e_pkg::CW;

  logic                 en;
  s3e_pkg::vec_t        in_v;

  logic                 sq_valid;
  s3e_pkg::tag_t        sq_tag;
  logic [63:0]          sq_t;

  logic                 rt_valid;
  logic [31:0]          rt_theta;
  s3e_pkg::tag_t        rt_tag;

  logic                 dv_valid;
  s3e_pkg::vec_t        dv_u;
  logic [31:0]          dv_theta;
  s3e_pkg::tag_t        dv_tag;

  logic                 sc_valid;
  logic signed [CW-1:0] sc_s;
  logic signed [CW-1:0] sc_omc;
  s3e_pkg::vec_t        sc_u;
  s3e_pkg::tag_t        sc_tag;

  logic                 cp_valid;
  s3e_pkg::mat_t        cp_m;

  s3e_pkg::mat_t        ent_r [2];
  logic                 wr_ptr_r;
  logic                 rd_ptr_r;
  logic [1:0]           cnt_r;
  logic                 push;
  logic                 pop;
  s3e_pkg::mat_t        head;

  assign in_v[0] = in_chan.rot_x;
  assign in_v[1] = in_chan.rot_y;
  assign in_v[2] = in_chan.rot_z;

  assign en            = (cnt_r != 2'd2);
  assign in_chan.ready = en;

  s3e_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_chan.valid),
    .in_v      (in_v),
    .out_valid (sq_valid),
    .out_tag   (sq_tag),
    .out_t     (sq_t)
  );

  s3e_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_t      (sq_t),
    .in_tag    (sq_tag),
    .out_valid (rt_valid),
    .out_theta (rt_theta),
    .out_tag   (rt_tag)
  );

  s3e_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_valid),
    .in_theta  (rt_theta),
    .in_tag    (rt_tag),
    .out_valid (dv_valid),
    .out_u     (dv_u),
    .out_theta (dv_theta),
    .out_tag   (dv_tag)
  );

  s3e_sincos u_sincos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .in_theta  (dv_theta),
    .in_u      (dv_u),
    .in_tag    (dv_tag),
    .out_valid (sc_valid),
    .out_s     (sc_s),
    .out_omc   (sc_omc),
    .out_u     (sc_u),
    .out_tag   (sc_tag)
  );

  s3e_compose u_compose (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sc_valid),
    .in_s      (sc_s),
    .in_omc    (sc_omc),
    .in_u      (sc_u),
    .in_tag    (sc_tag),
    .out_valid (cp_valid),
    .out_m     (cp_m)
  );

  assign push = en && cp_valid;
  assign pop  = (cnt_r != 2'd0) && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cp_m;
    end
  end

  assign head           = ent_r[rd_ptr_r];
  assign out_chan.valid = (cnt_r != 2'd0);
  assign out_chan.m00   = head.m00;
  assign out_chan.m01   = head.m01;
  assign out_chan.m02   = head.m02;
  assign out_chan.m10   = head.m10;
  assign out_chan.m11   = head.m11;
  assign out_chan.m12   = head.m12;
  assign out_chan.m20   = head.m20;
  assign out_chan.m21   = head.m21;
  assign out_chan.m22   = head.m22;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for so3_exponential_map: directed and random rotation vectors checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  s3e_in_if  vin ();
  s3e_out_if vout ();

  so3_exponential_map dut (.clk(clk), .rst_n(rst_n), .in_chan(vin.sink), .out_chan(vout.source));

  localparam longint ONE = 64'sd1073741824;
  localparam longint SMALL_LIMIT = 64'sd72058;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint PI = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN = 64'sd652032874;
  localparam int STEPS = 30;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } rotvec_t;

  typedef struct {
    rotvec_t       v;
    bit            typed;
    s3e_pkg::mat_t m;
  } stim_row_t;

  s3e_pkg::mat_t pending_mats[$];
  int     errors = 0;
  bit     stim_done = 1'b0;

  // Rounding and arithmetic shift on 64-bit signed values (>>> floors).
  function automatic longint round_shift(input longint v, input int k);
    return (v + (64'sd1 <<< (k - 1))) >>> k;
  endfunction

  function automatic longint arctan_step(input int i);
    longint head[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                         33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return head[i];
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 0;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp_entry(input longint v);
    if (v > ONE) return 32'sd1073741824;
    if (v < -ONE) return -32'sd1073741824;
    return v[31:0];
  endfunction

  function automatic s3e_pkg::mat_t rotation_matrix(input rotvec_t rv);
    longint v[3], m[9], u[3];
    longint unsigned t, mag;
    longint aq, bq, x, y, z, theta, r, s, c, omc, dx, dy;
    longint pxx, pyy, pzz, pxy, pxz, pyz;
    longint k1[9], k2[9];
    bit flip;
    s3e_pkg::mat_t res;
    v[0] = rv.x;
    v[1] = rv.y;
    v[2] = rv.z;
    t = 0;
    for (int i = 0; i < 3; i++) begin
      mag = v[i] < 0 ? -v[i] : v[i];
      t += mag * mag;
    end
    if (t < SMALL_LIMIT) begin
      x = v[0];
      y = v[1];
      z = v[2];
      aq = round_shift((64'sd1 <<< 60) - longint'((t << 4) / 6), 30);
      bq = round_shift((64'sd1 <<< 59) - longint'((t << 4) / 24), 30);
      k1 = '{0, -z, y, z, 0, -x, -y, x, 0};
      k2 = '{-(y*y + z*z), x*y, x*z, x*y, -(x*x + z*z), y*z, x*z, y*z, -(x*x + y*y)};
      for (int i = 0; i < 9; i++)
        m[i] = ((i % 4 == 0) ? ONE : 0) + round_shift(aq * k1[i], 28)
               + round_shift(bq * k2[i], 56);
    end else begin
      theta = longint'(int_sqrt(t));
      r = (theta * 4) % TWO_PI;
      flip = 1'b0;
      if (r > PI) r -= TWO_PI;
      if (r > HALF_PI) begin
        r = PI - r;
        flip = 1'b1;
      end else if (r < -HALF_PI) begin
        r = -PI - r;
        flip = 1'b1;
      end
      c = GAIN;
      s = 0;
      for (int i = 0; i < STEPS; i++) begin
        dx = s >>> i;
        dy = c >>> i;
        if (r >= 0) begin
          c -= dx;
          s += dy;
          r -= arctan_step(i);
        end else begin
          c += dx;
          s -= dy;
          r += arctan_step(i);
        end
      end
      if (flip) c = -c;
      omc = ONE - c;
      for (int i = 0; i < 3; i++) u[i] = (v[i] * ONE) / theta;
      pxx = round_shift(u[0] * u[0], 30);
      pyy = round_shift(u[1] * u[1], 30);
      pzz = round_shift(u[2] * u[2], 30);
      pxy = round_shift(u[0] * u[1], 30);
      pxz = round_shift(u[0] * u[2], 30);
      pyz = round_shift(u[1] * u[2], 30);
      m[0] = ONE + round_shift(omc * -(pyy + pzz), 30);
      m[1] = -round_shift(s * u[2], 30) + round_shift(omc * pxy, 30);
      m[2] = round_shift(s * u[1], 30) + round_shift(omc * pxz, 30);
      m[3] = round_shift(s * u[2], 30) + round_shift(omc * pxy, 30);
      m[4] = ONE + round_shift(omc * -(pxx + pzz), 30);
      m[5] = -round_shift(s * u[0], 30) + round_shift(omc * pyz, 30);
      m[6] = -round_shift(s * u[1], 30) + round_shift(omc * pxz, 30);
      m[7] = round_shift(s * u[0], 30) + round_shift(omc * pyz, 30);
      m[8] = ONE + round_shift(omc * -(pxx + pyy), 30);
    end
    res.m00 = clamp_entry(m[0]);
    res.m01 = clamp_entry(m[1]);
    res.m02 = clamp_entry(m[2]);
    res.m10 = clamp_entry(m[3]);
    res.m11 = clamp_entry(m[4]);
    res.m12 = clamp_entry(m[5]);
    res.m20 = clamp_entry(m[6]);
    res.m21 = clamp_entry(m[7]);
    res.m22 = clamp_entry(m[8]);
    return res;
  endfunction

  function automatic rotvec_t make_vec(input logic [31:0] x, input logic [31:0] y,
                                       input logic [31:0] z);
    rotvec_t rv;
    rv.x = x;
    rv.y = y;
    rv.z = z;
    return rv;
  endfunction

  function automatic logic signed [31:0] rand_component(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 600)) - 300;
      2: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
      default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  // Drives one vector and holds it until the transfer; valid stays high afterwards
  // so that a following vector with no gap goes out back to back.
  task automatic send_vec(input rotvec_t rv, input s3e_pkg::mat_t exp_m);
    int gap;
    gap = $urandom_range(0, 17);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    vin.valid <= 1'b1;
    vin.rot_x <= rv.x;
    vin.rot_y <= rv.y;
    vin.rot_z <= rv.z;
    @(posedge clk);
    while (!vin.ready) @(posedge clk);
    pending_mats.push_back(exp_m);
  endtask

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch expected %0d actual %0d", $time, name, $signed(e), $signed(a));
    end
  endtask

  // Result side: random stalls, compare each transfer with the oldest expectation.
  initial begin
    s3e_pkg::mat_t e;
    int gap;
    vout.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = 0;
      if ($urandom_range(0, 2) == 0) gap = $urandom_range(0, 17);
      if (gap > 0) begin
        vout.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      vout.ready <= 1'b1;
      @(posedge clk);
      while (!vout.valid) @(posedge clk);
      if (pending_mats.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no expected matrix", $time);
      end else begin
        e = pending_mats.pop_front();
        check_field("m00", e.m00, vout.m00);
        check_field("m01", e.m01, vout.m01);
        check_field("m02", e.m02, vout.m02);
        check_field("m10", e.m10, vout.m10);
        check_field("m11", e.m11, vout.m11);
        check_field("m12", e.m12, vout.m12);
        check_field("m20", e.m20, vout.m20);
        check_field("m21", e.m21, vout.m21);
        check_field("m22", e.m22, vout.m22);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    s3e_pkg::mat_t ident, e;
    rotvec_t rv;
    int mode;
    ident = '{32'sd1073741824, 0, 0, 0, 32'sd1073741824, 0, 0, 0, 32'sd1073741824};
    vin.valid = 1'b0;
    vin.rot_x = '0;
    vin.rot_y = '0;
    vin.rot_z = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Zero vector gives the identity; other rows use the predictor.
    row.typed = 1'b1;
    row.m = ident;
    row.v = make_vec(0, 0, 0);
    rows.push_back(row);
    row.typed = 1'b0;
    row.v = make_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff); rows.push_back(row);
    row.v = make_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000); rows.push_back(row);
    row.v = make_vec(32'h8000_0000, 0, 0);                         rows.push_back(row);
    row.v = make_vec(0, 32'h7fff_ffff, 0);                         rows.push_back(row);
    row.v = make_vec(0, 0, 32'h8000_0000);                         rows.push_back(row);
    row.v = make_vec(1, 0, 0);                                     rows.push_back(row);
    row.v = make_vec(-1, -1, -1);                                  rows.push_back(row);
    row.v = make_vec(155, 155, 155);                               rows.push_back(row);
    row.v = make_vec(155, 156, 155);                               rows.push_back(row);
    row.v = make_vec(268, 0, 0);                                   rows.push_back(row);
    row.v = make_vec(269, 0, 0);                                   rows.push_back(row);
    row.v = make_vec(32'sd421657428, 0, 0);                        rows.push_back(row);
    row.v = make_vec(0, -32'sd843314857, 0);                       rows.push_back(row);
    row.v = make_vec(0, 0, 32'sd843314857);                        rows.push_back(row);
    row.v = make_vec(32'sd268435456, 32'sd268435456, -32'sd268435456); rows.push_back(row);
    row.v = make_vec(32'sd1686629713, 0, 0);                       rows.push_back(row);
    row.v = make_vec(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555); rows.push_back(row);
    row.v = make_vec(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa); rows.push_back(row);

    foreach (rows[i]) begin
      e = rows[i].typed ? rows[i].m : rotation_matrix(rows[i].v);
      send_vec(rows[i].v, e);
    end

    for (int n = 0; n < 1650; n++) begin
      // Let the block drain completely once, mid-run.
      if (n == 800) begin
        vin.valid <= 1'b0;
        wait (pending_mats.size() == 0);
      end
      mode = $urandom_range(0, 3);
      rv = make_vec(rand_component(mode), rand_component(mode), rand_component(mode));
      send_vec(rv, rotation_matrix(rv));
    end
    vin.valid <= 1'b0;

    while (pending_mats.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("** so3_exponential_map: PASSED **");
    end else begin
      $display("** so3_exponential_map: FAILED **");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("** so3_exponential_map: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/s3e_pkg.sv
rtl/s3e_in_if.sv
rtl/s3e_out_if.sv
rtl/s3e_square.sv
rtl/s3e_sqrt.sv
rtl/s3e_div.sv
rtl/s3e_sincos.sv
rtl/s3e_compose.sv
rtl/so3_exponential_map.sv
tb/tb_top.sv
